// ===== rtl/alist_pkg.sv =====
`default_nettype none
package alist_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int CMD_W    = 4;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    localparam logic [CMD_W-1:0] CMD_INS_POS   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_INS_FIRST = 4'd1;
    localparam logic [CMD_W-1:0] CMD_INS_LAST  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_POS   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_KEY   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_READ      = 4'd5;
    localparam logic [CMD_W-1:0] CMD_REPLACE   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_SEARCH    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd8;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_POSITION = 2'd2,
        ST_ABSENT   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic load;
        logic match_en;
        logic apply;
    } dp_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/alist_ctrl.sv =====
`default_nettype none
module alist_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output alist_pkg::dp_cmd_t      dp_cmd
);

    alist_pkg::state_t state_reg;
    alist_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              apply_go;
    logic              accept;

    // Finish a command only when the output register is free or being emptied.
    assign apply_go = (state_reg == alist_pkg::S_APPLY) && (!out_valid_reg || !out_stall);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            alist_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = alist_pkg::S_MATCH;
            end
            alist_pkg::S_MATCH:
            begin
                state_next = alist_pkg::S_APPLY;
            end
            alist_pkg::S_APPLY:
            begin
                if (apply_go)
                    state_next = accept ? alist_pkg::S_MATCH : alist_pkg::S_IDLE;
            end
            default:
            begin
                state_next = alist_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall        = 1'b1;
        dp_cmd.match_en = 1'b0;
        dp_cmd.apply    = 1'b0;
        unique case (state_reg)
            alist_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
            end
            alist_pkg::S_MATCH:
            begin
                dp_cmd.match_en = 1'b1;
            end
            alist_pkg::S_APPLY:
            begin
                in_stall     = !apply_go;
                dp_cmd.apply = apply_go;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
        dp_cmd.load = in_valid && !in_stall;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (apply_go)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= alist_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/alist_dp.sv =====
`default_nettype none
module alist_dp
#(
    parameter int CAPACITY = alist_pkg::CAPACITY_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire alist_pkg::dp_cmd_t                   dp_cmd,
    input  wire logic        [alist_pkg::CMD_W-1:0]   command,
    input  wire logic        [alist_pkg::POS_W-1:0]   position,
    input  wire logic signed [alist_pkg::VAL_W-1:0]   value,
    output logic signed      [alist_pkg::VAL_W-1:0]   item,
    output logic                                      found,
    output logic             [alist_pkg::STATUS_W-1:0] status,
    output logic             [alist_pkg::LEN_W-1:0]   length
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMPW = ((CW > alist_pkg::POS_W) ? CW : alist_pkg::POS_W) + 1;

    logic signed [alist_pkg::VAL_W-1:0] cell_reg  [CAPACITY];
    logic signed [alist_pkg::VAL_W-1:0] cell_next [CAPACITY];
    logic signed [alist_pkg::VAL_W-1:0] up_src    [CAPACITY];
    logic signed [alist_pkg::VAL_W-1:0] dn_src    [CAPACITY];

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] match_next;

    logic        [alist_pkg::CMD_W-1:0] cmd_reg;
    logic        [alist_pkg::POS_W-1:0] pos_reg;
    logic signed [alist_pkg::VAL_W-1:0] val_reg;

    logic signed [alist_pkg::VAL_W-1:0]    item_reg;
    logic signed [alist_pkg::VAL_W-1:0]    item_next;
    logic                                  found_reg;
    logic                                  found_next;
    alist_pkg::status_t                    status_reg;
    alist_pkg::status_t                    status_next;
    logic        [alist_pkg::LEN_W-1:0]    length_reg;

    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic [CMPW-1:0] cap_x;
    logic [CMPW-1:0] ins_at;
    logic [CMPW-1:0] del_at;
    logic            ins_en;
    logic            del_en;
    logic            rep_en;
    logic            full;
    logic            hit;
    logic [IW-1:0]   hit_idx;
    logic [IW-1:0]   rd_idx;
    logic signed [alist_pkg::VAL_W-1:0] rd_data;

    assign pos_x = CMPW'(pos_reg);
    assign cnt_x = CMPW'(count_reg);
    assign cap_x = CMPW'(CAPACITY);
    assign full  = (cnt_x >= cap_x);

    // Compare the key against every live cell in one pass.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            match_next[i] = (cell_reg[i] == val_reg) && (count_reg > CW'(i));
    end

    assign hit = |match_reg;

    always_comb
    begin
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match_reg[i])
                hit_idx = IW'(i);
        end
    end

    assign rd_idx  = (cmd_reg == alist_pkg::CMD_DEL_KEY) ? hit_idx : pos_reg[IW-1:0];
    assign rd_data = cell_reg[rd_idx];

    always_comb
    begin
        ins_en      = 1'b0;
        del_en      = 1'b0;
        rep_en      = 1'b0;
        ins_at      = '0;
        del_at      = '0;
        item_next   = '0;
        found_next  = 1'b0;
        status_next = alist_pkg::ST_OK;
        count_next  = count_reg;
        unique case (cmd_reg)
            alist_pkg::CMD_INS_POS:
            begin
                if (!full && (pos_x <= cnt_x))
                begin
                    ins_en = 1'b1;
                    ins_at = pos_x;
                end
                else
                    status_next = alist_pkg::ST_OVERFLOW;
            end
            alist_pkg::CMD_INS_FIRST:
            begin
                if (!full)
                    ins_en = 1'b1;
                else
                    status_next = alist_pkg::ST_OVERFLOW;
            end
            alist_pkg::CMD_INS_LAST:
            begin
                if (!full)
                begin
                    ins_en = 1'b1;
                    ins_at = cnt_x;
                end
                else
                    status_next = alist_pkg::ST_OVERFLOW;
            end
            alist_pkg::CMD_DEL_POS:
            begin
                if (pos_x < cnt_x)
                begin
                    del_en    = 1'b1;
                    del_at    = pos_x;
                    item_next = rd_data;
                end
                else
                    status_next = alist_pkg::ST_POSITION;
            end
            alist_pkg::CMD_DEL_KEY:
            begin
                if (hit)
                begin
                    del_en     = 1'b1;
                    del_at     = CMPW'(hit_idx);
                    item_next  = rd_data;
                    found_next = 1'b1;
                end
                else
                    status_next = alist_pkg::ST_ABSENT;
            end
            alist_pkg::CMD_READ:
            begin
                if (pos_x < cnt_x)
                    item_next = rd_data;
                else
                    status_next = alist_pkg::ST_POSITION;
            end
            alist_pkg::CMD_REPLACE:
            begin
                if (pos_x < cap_x)
                    rep_en = 1'b1;
                else
                    status_next = alist_pkg::ST_POSITION;
            end
            alist_pkg::CMD_SEARCH:
            begin
                if (hit)
                    found_next = 1'b1;
                else
                    status_next = alist_pkg::ST_ABSENT;
            end
            alist_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        if (ins_en)
            count_next = count_reg + CW'(1);
        else if (del_en)
            count_next = count_reg - CW'(1);
    end

    // Neighbor taps for the parallel shift; the edge cells feed themselves.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_lo
            assign up_src[i] = cell_reg[i];
        end
        else
        begin : g_lo
            assign up_src[i] = cell_reg[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_hi
            assign dn_src[i] = cell_reg[i];
        end
        else
        begin : g_hi
            assign dn_src[i] = cell_reg[i+1];
        end

        always_comb
        begin
            cell_next[i] = cell_reg[i];
            if (ins_en)
            begin
                if (CMPW'(i) == ins_at)
                    cell_next[i] = val_reg;
                else if ((CMPW'(i) > ins_at) && (CMPW'(i) <= cnt_x))
                    cell_next[i] = up_src[i];
            end
            else if (del_en)
            begin
                if ((CMPW'(i) >= del_at) && ((CMPW'(i) + CMPW'(1)) < cnt_x))
                    cell_next[i] = dn_src[i];
            end
            else if (rep_en)
            begin
                if (CMPW'(i) == pos_x)
                    cell_next[i] = val_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (dp_cmd.apply)
                cell_reg[i] <= cell_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (dp_cmd.apply)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg <= command;
            pos_reg <= position;
            val_reg <= value;
        end
        if (dp_cmd.match_en)
            match_reg <= match_next;
        if (dp_cmd.apply)
        begin
            item_reg   <= item_next;
            found_reg  <= found_next;
            status_reg <= status_next;
            length_reg <= alist_pkg::LEN_W'(count_next);
        end
    end

    assign item   = item_reg;
    assign found  = found_reg;
    assign status = status_reg;
    assign length = length_reg;

endmodule
`default_nettype wire

// ===== rtl/array_list_engine.sv =====
`default_nettype none
// Channel | Handshake           | Words
// --------+---------------------+------------------------------------
// in      | in_valid / in_stall | command, position, value
// out     | out_valid/out_stall | item, found, status, length
//
// Each command passes a match state that compares the key against all cells,
// then an apply state: shift or update the cells, load the result register.
// A new command is taken in the cycle the previous one finishes.
// Reset clears the count and control state; cell and result data are undefined.
// A stalled result holds in the output register; the next command runs up to
// its final cycle and waits there until the result register frees.
module array_list_engine
#(
    parameter int CAPACITY = alist_pkg::CAPACITY_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic        [alist_pkg::CMD_W-1:0]    command,
    input  wire logic        [alist_pkg::POS_W-1:0]    position,
    input  wire logic signed [alist_pkg::VAL_W-1:0]    value,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed      [alist_pkg::VAL_W-1:0]    item,
    output logic                                       found,
    output logic             [alist_pkg::STATUS_W-1:0] status,
    output logic             [alist_pkg::LEN_W-1:0]    length
);

    alist_pkg::dp_cmd_t dp_cmd;

    alist_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd)
    );

    alist_dp
    #(
        .CAPACITY (CAPACITY)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .dp_cmd   (dp_cmd),
        .command  (command),
        .position (position),
        .value    (value),
        .item     (item),
        .found    (found),
        .status   (status),
        .length   (length)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import alist_pkg::*;

    localparam int LIST_CAP    = CAPACITY_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_CMDS = 1225;
    localparam int LONG_HOLD   = 80;

    localparam logic [CMD_W-1:0] CMD_LAST_CODE = 4'hF;

    localparam int PHASE_GROW   = 0;
    localparam int PHASE_SHRINK = 1;
    localparam int PHASE_MIXED  = 2;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        bit                      drain;
    } list_cmd_t;

    typedef struct {
        logic signed [VAL_W-1:0] item;
        logic                    found;
        status_t                 status;
        logic [LEN_W-1:0]        length;
    } list_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [CMD_W-1:0]            command = '0;
    logic [POS_W-1:0]            position = '0;
    logic signed [VAL_W-1:0]     value = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [VAL_W-1:0]     item;
    logic                        found;
    logic [STATUS_W-1:0]         status;
    logic [LEN_W-1:0]            length;

    list_cmd_t    cmd_backlog[$];
    list_result_t pending_results[$];

    // shadow copy of the list
    logic signed [VAL_W-1:0] cells [LIST_CAP];
    int fill = 0;
    int peak_fill = 0;
    int full_rejects = 0;
    int key_hits = 0;

    int words_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int send_gap = 0;
    int recv_wait = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    bit sender_calm = 1'b0;
    bit receiver_calm = 1'b0;

    logic signed [VAL_W-1:0] key_pool [8] = '{
        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, -32'sd1,
        32'sd1, 32'sd2, 32'sd3, 32'sh55AA_55AA
    };

    array_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .position  (position),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .item      (item),
        .found     (found),
        .status    (status),
        .length    (length)
    );

    always #5 clk = ~clk;

    function automatic void insert_at(int at, logic signed [VAL_W-1:0] v);
        for (int i = fill; i > at; i--)
            cells[i] = cells[i - 1];
        cells[at] = v;
        fill++;
        if (fill > peak_fill)
            peak_fill = fill;
    endfunction

    function automatic logic signed [VAL_W-1:0] remove_at(int at);
        logic signed [VAL_W-1:0] gone;
        gone = cells[at];
        for (int i = at; i + 1 < fill; i++)
            cells[i] = cells[i + 1];
        fill--;
        return gone;
    endfunction

    function automatic list_result_t apply_command(logic [CMD_W-1:0] cmd,
                                                   logic [POS_W-1:0] pos,
                                                   logic signed [VAL_W-1:0] val);
        list_result_t r;
        int hit;
        r.item   = '0;
        r.found  = 1'b0;
        r.status = ST_OK;
        hit = -1;
        for (int i = 0; i < fill; i++)
            if (hit < 0 && cells[i] == val)
                hit = i;
        case (cmd)
            CMD_INS_POS, CMD_INS_FIRST, CMD_INS_LAST:
            begin
                if (fill >= LIST_CAP) begin
                    r.status = ST_OVERFLOW;
                    full_rejects++;
                end else if (cmd == CMD_INS_FIRST)
                    insert_at(0, val);
                else if (cmd == CMD_INS_LAST)
                    insert_at(fill, val);
                else if (int'(pos) <= fill)
                    insert_at(int'(pos), val);
                else
                    r.status = ST_OVERFLOW;
            end
            CMD_DEL_POS:
            begin
                if (int'(pos) < fill)
                    r.item = remove_at(int'(pos));
                else
                    r.status = ST_POSITION;
            end
            CMD_DEL_KEY:
            begin
                if (hit >= 0) begin
                    r.item  = remove_at(hit);
                    r.found = 1'b1;
                    key_hits++;
                end else
                    r.status = ST_ABSENT;
            end
            CMD_READ:
            begin
                if (int'(pos) < fill)
                    r.item = cells[pos];
                else
                    r.status = ST_POSITION;
            end
            CMD_REPLACE:
            begin
                if (int'(pos) < LIST_CAP)
                    cells[pos] = val;
                else
                    r.status = ST_POSITION;
            end
            CMD_SEARCH:
            begin
                if (hit >= 0) begin
                    r.found = 1'b1;
                    key_hits++;
                end else
                    r.status = ST_ABSENT;
            end
            CMD_CLEAR:
                fill = 0;
            default:
                ;
        endcase
        r.length = fill[LEN_W-1:0];
        return r;
    endfunction

    function automatic void note_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s", $time, what);
    endfunction

    function automatic void push_cmd(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                     logic signed [VAL_W-1:0] val, bit drain = 1'b0);
        list_cmd_t c;
        c.cmd   = cmd;
        c.pos   = pos;
        c.val   = val;
        c.drain = drain;
        cmd_backlog.push_back(c);
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(int mode);
        int roll;
        int ins_share;
        int del_share;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return CMD_W'($urandom_range(int'(CMD_CLEAR) + 1, int'(CMD_LAST_CODE)));
        if (roll < 3 && mode != PHASE_GROW)
            return CMD_CLEAR;
        ins_share = (mode == PHASE_GROW) ? 70 : (mode == PHASE_SHRINK) ? 12 : 35;
        del_share = (mode == PHASE_GROW) ? 8 : (mode == PHASE_SHRINK) ? 60 : 25;
        roll = $urandom_range(0, 99);
        if (roll < ins_share) begin
            case ($urandom_range(0, 2))
                0:       return CMD_INS_POS;
                1:       return CMD_INS_FIRST;
                default: return CMD_INS_LAST;
            endcase
        end
        if (roll < ins_share + del_share)
            return ($urandom_range(0, 1) == 0) ? CMD_DEL_POS : CMD_DEL_KEY;
        case ($urandom_range(0, 2))
            0:       return CMD_READ;
            1:       return CMD_REPLACE;
            default: return CMD_SEARCH;
        endcase
    endfunction

    function automatic void build_random(int n);
        int mode;
        int phase_left;
        int roll;
        logic [POS_W-1:0] pos;
        logic signed [VAL_W-1:0] val;
        mode = PHASE_GROW;
        phase_left = 0;
        for (int k = 0; k < n; k++) begin
            if (phase_left == 0) begin
                mode = $urandom_range(PHASE_GROW, PHASE_MIXED);
                phase_left = $urandom_range(30, 60);
            end
            phase_left--;
            roll = $urandom_range(0, 9);
            if (roll == 0)
                pos = POS_W'($urandom_range(0, 255));
            else if (roll == 1)
                pos = POS_W'($urandom_range(0, 3));
            else
                pos = POS_W'($urandom_range(0, LIST_CAP + 1));
            // small key pool so searches and deletes by key often hit duplicates
            if ($urandom_range(0, 9) < 6)
                val = key_pool[$urandom_range(0, 7)];
            else
                val = $urandom;
            push_cmd(pick_command(mode), pos, val,
                     k == n / 2 || k == n - 100 || $urandom_range(0, 199) == 0);
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n) begin
        list_cmd_t word;
        if (!rst_n) begin
            in_valid <= 1'b0;
            command  <= '0;
            position <= '0;
            value    <= '0;
            send_gap = 0;
        end else begin
            if (in_valid && !in_stall) begin
                pending_results.push_back(apply_command(command, position, value));
                words_sent++;
                if (words_sent % 64 == 0)
                    sender_calm = ($urandom_range(0, 2) == 0);
                send_gap = sender_calm ? 0 : $urandom_range(0, 8);
            end
            if (!in_valid || !in_stall) begin
                // a drain word waits until every earlier result is back
                if (send_gap == 0 && cmd_backlog.size() != 0 &&
                    !(cmd_backlog[0].drain && results_seen != words_sent)) begin
                    word = cmd_backlog.pop_front();
                    command  <= word.cmd;
                    position <= word.pos;
                    value    <= word.val;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                    if (send_gap != 0)
                        send_gap--;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n) begin
        list_result_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0)
                    note_mismatch($sformatf("unexpected word item=%0d found=%0b status=%0d length=%0d",
                                            item, found, status, length));
                else begin
                    want = pending_results.pop_front();
                    if (item !== want.item || found !== want.found ||
                        status !== want.status || length !== want.length)
                        note_mismatch($sformatf(
                            "word %0d: exp item=%0d found=%0b status=%0d length=%0d, got item=%0d found=%0b status=%0d length=%0d",
                            results_seen, want.item, want.found, want.status, want.length,
                            item, found, status, length));
                end
                results_seen <= results_seen + 1;
                if ((results_seen + 1) % 64 == 0)
                    receiver_calm = ($urandom_range(0, 2) == 0);
                recv_wait = receiver_calm ? 0 : $urandom_range(0, 8);
                // hold off long enough for the engine to back up into its input
                if (results_seen + 1 == 300 || results_seen + 1 == 900)
                    hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (recv_wait != 0) begin
                recv_wait--;
                out_stall <= 1'b1;
            end else
                out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("array_list_engine: mismatch");
            $finish;
        end
    end

    initial begin
        // empty list: error paths of read, delete, search and insert at a position
        push_cmd(CMD_READ, 8'd0, 32'sd0);
        push_cmd(CMD_DEL_POS, 8'd0, 32'sd0);
        push_cmd(CMD_DEL_KEY, 8'd0, 32'sd0);
        push_cmd(CMD_SEARCH, 8'd0, -32'sd1);
        push_cmd(CMD_INS_POS, 8'd1, 32'sd9);
        // build a short list with a duplicate key
        push_cmd(CMD_INS_POS, 8'd0, 32'sh8000_0000);
        push_cmd(CMD_INS_FIRST, 8'd0, 32'sh7FFF_FFFF);
        push_cmd(CMD_INS_LAST, 8'd0, -32'sd1);
        push_cmd(CMD_INS_POS, 8'd3, 32'sh1234_5678);
        push_cmd(CMD_INS_POS, 8'd1, 32'sd1);
        push_cmd(CMD_INS_POS, 8'd2, 32'sh7FFF_FFFF);
        push_cmd(CMD_READ, 8'd0, 32'sd0);
        push_cmd(CMD_READ, 8'd5, 32'sd0);
        push_cmd(CMD_READ, 8'd6, 32'sd0);
        push_cmd(CMD_SEARCH, 8'd0, 32'sh7FFF_FFFF);
        push_cmd(CMD_DEL_KEY, 8'd0, 32'sh7FFF_FFFF);
        push_cmd(CMD_DEL_POS, 8'd255, 32'sd0);
        push_cmd(CMD_DEL_POS, 8'd4, 32'sd0);
        // replace beyond the length but inside capacity
        push_cmd(CMD_REPLACE, 8'd15, 32'sh5AA5_C33C);
        push_cmd(CMD_REPLACE, 8'd16, 32'sd0);
        push_cmd(CMD_REPLACE, 8'd255, -32'sd1);
        push_cmd(CMD_LAST_CODE, 8'd255, -32'sd1);
        push_cmd(CMD_CLEAR, 8'd0, 32'sd0);
        push_cmd(CMD_INS_LAST, 8'd0, 32'sd7);
        push_cmd(CMD_READ, 8'd0, 32'sd0, 1'b1);
        build_random(RANDOM_CMDS);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (cmd_backlog.size() != 0 || in_valid || results_seen < words_sent)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d expected words never arrived", pending_results.size()));

        $display("%0d commands, %0d results; list peaked at %0d of %0d entries",
                 words_sent, results_seen, peak_fill, LIST_CAP);
        $display("inserts rejected on a full list: %0d, key matches: %0d, mismatches: %0d",
                 full_rejects, key_hits, mismatches);
        if (mismatches == 0)
            $display("array_list_engine: match");
        else
            $display("array_list_engine: mismatch");
        $finish;
    end

endmodule

// ===== array_list_engine.f =====
rtl/alist_pkg.sv
rtl/alist_ctrl.sv
rtl/alist_dp.sv
rtl/array_list_engine.sv
tb/sv/tb_top.sv
